/* rtl/core/tts_pkg.sv */
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants, command codes and control structs of the text terminal.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int SCROLL_LEN = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Fixed field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {COLOR_RESET, CHAR_SPACE};

  // Datapath operation codes
  localparam logic [2:0] OP_IDLE   = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_COPY   = 3'd2;
  localparam logic [2:0] OP_FILL   = 3'd3;
  localparam logic [2:0] OP_FINISH = 3'd4;

  typedef struct packed {
    logic       accept;   // input transaction taken this cycle
    logic [2:0] op;       // datapath operation
    logic       cnt_clr;  // restart the sweep counter
  } cmd_t;

  typedef struct packed {
    logic need_scroll;  // the accepted put pushes the cursor past the last row
    logic cnt_last;     // sweep counter on the last step of the current op
    logic out_free;     // output register can take a result this cycle
  } status_t;

endpackage

/* rtl/core/tts_ctrl.sv */
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: screen clear, item acceptance, scroll copy and fill, result hand-off.
// ----------------------------------------------------------------------------
module tts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tts_pkg::status_t status,
  output tts_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = 1'b0;
    cmd.op      = tts_pkg::OP_IDLE;
    cmd.cnt_clr = 1'b0;
    in_stall    = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = tts_pkg::OP_CLEAR;
        if (status.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = status.need_scroll ? S_COPY : S_FINISH;
        end
      end
      S_COPY: begin
        cmd.op = tts_pkg::OP_COPY;
        if (status.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_FILL;
        end
      end
      S_FILL: begin
        cmd.op = tts_pkg::OP_FILL;
        if (status.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.op = tts_pkg::OP_FINISH;
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/tts_datapath.sv */
// ----------------------------------------------------------------------------
// tts_datapath
// Screen memory, cursor, color register, sweep counter and output register.
// ----------------------------------------------------------------------------
module tts_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tts_pkg::cmd_t                 cmd,
  output tts_pkg::status_t              status,
  input  logic                          cfg_wr_en,
  input  logic [tts_pkg::CHAR_W-1:0]    cfg_wr_data,
  input  logic                          in_mode,
  input  logic [tts_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tts_pkg::ROW_W-1:0]     in_read_row,
  input  logic [tts_pkg::COL_W-1:0]     in_read_column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tts_pkg::CELL_W-1:0]    out_cell_value,
  output logic [tts_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tts_pkg::COL_W-1:0]     out_cursor_column,
  output logic                          out_scrolled
);

  localparam int AW = tts_pkg::ADDR_W;
  localparam int RW = tts_pkg::ROW_W;
  localparam int CW = tts_pkg::COL_W;
  localparam int DW = tts_pkg::CELL_W;

  logic [DW-1:0] mem [tts_pkg::CELL_COUNT];

  logic [RW-1:0]               row_r, row_nxt;
  logic [CW-1:0]               col_r, col_nxt;
  logic [tts_pkg::CHAR_W-1:0]  color_r;
  logic [AW-1:0]               cnt_r, cnt_nxt;
  logic                        mode_r;
  logic                        inrange_r;
  logic                        scroll_r;
  logic [DW-1:0]               put_val_r;
  logic [DW-1:0]               rd_data_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [DW-1:0]               out_cell_r;
  logic [RW-1:0]               out_row_r;
  logic [CW-1:0]               out_col_r;
  logic                        out_scroll_r;

  logic          is_nl;
  logic [CW-1:0] col_inc;
  logic          wrap;
  logic          need_scroll;
  logic          in_range;
  logic [DW-1:0] entry;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] item_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic          load_out;
  logic          cnt_last;
  logic          out_free;

  // Put decode
  assign is_nl       = (in_char_code == tts_pkg::CHAR_NEWLINE);
  assign col_inc     = col_r + CW'(1);
  assign wrap        = is_nl || (col_inc == CW'(tts_pkg::COLUMNS));
  assign need_scroll = !in_mode && wrap && (row_r == RW'(tts_pkg::ROWS - 1));
  assign entry       = {color_r, in_char_code};
  assign cur_addr    = AW'(row_r) * AW'(tts_pkg::COLUMNS) + AW'(col_r);
  assign in_range    = (in_read_row < RW'(tts_pkg::ROWS)) &&
                       (in_read_column < CW'(tts_pkg::COLUMNS));
  assign item_addr   = AW'(in_read_row) * AW'(tts_pkg::COLUMNS) + AW'(in_read_column);

  always_comb begin
    cnt_last = 1'b0;
    case (cmd.op)
      tts_pkg::OP_CLEAR: cnt_last = (cnt_r == AW'(tts_pkg::CELL_COUNT - 1));
      tts_pkg::OP_COPY:  cnt_last = (cnt_r == AW'(tts_pkg::SCROLL_LEN));
      tts_pkg::OP_FILL:  cnt_last = (cnt_r == AW'(tts_pkg::COLUMNS - 1));
      default:           cnt_last = 1'b0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign status   = {need_scroll, cnt_last, out_free};
  assign load_out = (cmd.op == tts_pkg::OP_FINISH) && out_free;

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = entry;
    re    = 1'b0;
    raddr = item_addr;
    case (cmd.op)
      tts_pkg::OP_IDLE: begin
        we = cmd.accept && !in_mode && !is_nl;
        re = cmd.accept && in_mode && in_range;
      end
      tts_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_r;
        wdata = tts_pkg::BLANK_CELL;
      end
      tts_pkg::OP_COPY: begin
        // read one row ahead, write the previous step's data one slot back
        we    = (cnt_r != '0);
        waddr = cnt_r - AW'(1);
        wdata = rd_data_r;
        re    = !cnt_last;
        raddr = cnt_r + AW'(tts_pkg::COLUMNS);
      end
      tts_pkg::OP_FILL: begin
        we    = 1'b1;
        waddr = AW'(tts_pkg::SCROLL_LEN) + cnt_r;
        wdata = {color_r, tts_pkg::CHAR_SPACE};
      end
      default: begin
        we = 1'b0;
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  // Cursor update
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.accept && !in_mode) begin
      col_nxt = wrap ? '0 : col_inc;
      if (need_scroll) begin
        row_nxt = RW'(tts_pkg::ROWS - 1);
      end else if (wrap) begin
        row_nxt = row_r + RW'(1);
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.op == tts_pkg::OP_CLEAR || cmd.op == tts_pkg::OP_COPY ||
                 cmd.op == tts_pkg::OP_FILL) begin
      cnt_nxt = cnt_r + AW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      color_r     <= tts_pkg::COLOR_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r    <= in_mode;
      inrange_r <= in_range;
      scroll_r  <= need_scroll;
      put_val_r <= is_nl ? '0 : entry;
    end
    if (load_out) begin
      out_cell_r   <= mode_r ? (inrange_r ? rd_data_r : '0) : put_val_r;
      out_row_r    <= row_r;
      out_col_r    <= col_r;
      out_scroll_r <= !mode_r && scroll_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_value    = out_cell_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;
  assign out_scrolled      = out_scroll_r;

endmodule

/* rtl/core/text_terminal_cursor_scroll.sv */
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// 80x25 text terminal with cursor, newline, line wrap, scroll and cell reads.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole screen memory to grey blanks (0x0720),
// one cell a cycle, holding in_stall high until it is done; configuration
// writes are taken during that time. A put or read transaction is accepted in
// the idle state, touching the screen memory (one read port and one write
// port), and its result goes to the output register in the finish state, which
// waits while that register is full and stalled; the register can hold a
// finished result while the next transaction is taken. A put that moves the
// cursor past the last row scrolls the screen: the copy engine moves 1920
// cells up one row at one memory write a cycle and then writes an 80-cell
// blank line in the current color. Write text_color only while no transaction
// is in flight; it colors every new cell and the blank line of a scroll.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tts_pkg::CHAR_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [tts_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tts_pkg::ROW_W-1:0]     in_read_row,
  input  logic [tts_pkg::COL_W-1:0]     in_read_column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tts_pkg::CELL_W-1:0]    out_cell_value,
  output logic [tts_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tts_pkg::COL_W-1:0]     out_cursor_column,
  output logic                          out_scrolled
);

  tts_pkg::cmd_t    cmd;
  tts_pkg::status_t status;

  // Sequencer: owns the clear sweep, scroll phases and the input handshake
  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: screen memory, cursor, color and the output register
  tts_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_mode           (in_mode),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_value    (out_cell_value),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column),
    .out_scrolled      (out_scrolled)
  );

endmodule

/* sim/tts_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_tb_pkg
// Transaction mode codes and the result record shared by the testbench files.
// ----------------------------------------------------------------------------
package tts_tb_pkg;

  typedef enum logic {
    MODE_PUT  = 1'b0,
    MODE_READ = 1'b1
  } term_mode_e;

  typedef struct packed {
    logic [tts_pkg::CELL_W-1:0] cell_value;
    logic [tts_pkg::ROW_W-1:0]  row;
    logic [tts_pkg::COL_W-1:0]  col;
    logic                       scrolled;
  } term_reply_t;

endpackage

/* sim/tts_reply_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_reply_check
// Watches the terminal's channels, keeps its own screen, cursor and color,
// predicts each result and compares it field by field on the output channel.
// ----------------------------------------------------------------------------
module tts_reply_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tts_pkg::CHAR_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_mode,
  input  logic [tts_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tts_pkg::ROW_W-1:0]  in_read_row,
  input  logic [tts_pkg::COL_W-1:0]  in_read_column,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [tts_pkg::CELL_W-1:0] out_cell_value,
  input  logic [tts_pkg::ROW_W-1:0]  out_cursor_row,
  input  logic [tts_pkg::COL_W-1:0]  out_cursor_column,
  input  logic                       out_scrolled,
  output int                         error_count,
  output int                         pending_results
);

  logic [tts_pkg::CELL_W-1:0] screen [tts_pkg::CELL_COUNT];
  logic [tts_pkg::CHAR_W-1:0] text_color;
  int                         cur_row;
  int                         cur_col;
  int                         errors;
  tts_tb_pkg::term_reply_t    terminal_reply_q[$];

  initial begin
    errors          = 0;
    error_count     = 0;
    pending_results = 0;
  end

  // Apply one put or read to the local terminal and return its result.
  function automatic tts_tb_pkg::term_reply_t apply_terminal_item(
      logic mode, logic [tts_pkg::CHAR_W-1:0] ch,
      logic [tts_pkg::ROW_W-1:0] rrow, logic [tts_pkg::COL_W-1:0] rcol);
    tts_tb_pkg::term_reply_t    r;
    logic [tts_pkg::CELL_W-1:0] entry;
    r = '0;
    if (mode == tts_tb_pkg::MODE_READ) begin
      if (int'(rrow) < tts_pkg::ROWS && int'(rcol) < tts_pkg::COLUMNS)
        r.cell_value = screen[int'(rrow) * tts_pkg::COLUMNS + int'(rcol)];
    end else begin
      if (ch == tts_pkg::CHAR_NEWLINE) begin
        cur_row++;
        cur_col = 0;
      end else begin
        entry = {text_color, ch};
        screen[cur_row * tts_pkg::COLUMNS + cur_col] = entry;
        r.cell_value = entry;
        cur_col++;
        if (cur_col >= tts_pkg::COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      // Scroll up one line and blank the bottom line in the current color.
      if (cur_row >= tts_pkg::ROWS) begin
        for (int i = 0; i < tts_pkg::SCROLL_LEN; i++)
          screen[i] = screen[i + tts_pkg::COLUMNS];
        for (int i = tts_pkg::SCROLL_LEN; i < tts_pkg::CELL_COUNT; i++)
          screen[i] = {text_color, tts_pkg::CHAR_SPACE};
        cur_row = tts_pkg::ROWS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.row = cur_row[tts_pkg::ROW_W-1:0];
    r.col = cur_col[tts_pkg::COL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : track
    tts_tb_pkg::term_reply_t want;
    tts_tb_pkg::term_reply_t got;
    if (!rst_n) begin
      text_color = tts_pkg::COLOR_RESET;
      cur_row    = 0;
      cur_col    = 0;
      foreach (screen[i]) screen[i] = tts_pkg::BLANK_CELL;
      terminal_reply_q.delete();
    end else begin
      if (cfg_wr_en)
        text_color = cfg_wr_data;
      // Retire the result first so it never meets a transaction taken this edge.
      if (out_valid && !out_stall) begin
        got.cell_value = out_cell_value;
        got.row        = out_cursor_row;
        got.col        = out_cursor_column;
        got.scrolled   = out_scrolled;
        if (terminal_reply_q.size() == 0) begin
          $error("unexpected result: cell_value %h cursor %0d,%0d scrolled %b",
                 got.cell_value, got.row, got.col, got.scrolled);
          errors++;
        end else begin
          want = terminal_reply_q.pop_front();
          if (got.cell_value !== want.cell_value) begin
            $error("cell_value mismatch: expected %h, actual %h",
                   want.cell_value, got.cell_value);
            errors++;
          end
          if (got.row !== want.row) begin
            $error("cursor_row mismatch: expected %0d, actual %0d", want.row, got.row);
            errors++;
          end
          if (got.col !== want.col) begin
            $error("cursor_column mismatch: expected %0d, actual %0d", want.col, got.col);
            errors++;
          end
          if (got.scrolled !== want.scrolled) begin
            $error("scrolled mismatch: expected %b, actual %b", want.scrolled, got.scrolled);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        terminal_reply_q.push_back(apply_terminal_item(in_mode, in_char_code,
                                                       in_read_row, in_read_column));
    end
    pending_results <= terminal_reply_q.size();
    error_count     <= errors;
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 80x25 text terminal: directed puts, newlines
// and edge reads, then random traffic across several text colors with bursty
// input, random output stalls, one long output hold-off and full drains.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 366;   // random transactions per color phase
  localparam int HOLD_CYCLES = 500;   // long output hold-off
  localparam int IDLE_LIMIT  = 20000; // cycles with no transaction on either side
  localparam int TAIL_CYCLES = 20;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [tts_pkg::CHAR_W-1:0] cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_mode;
  logic [tts_pkg::CHAR_W-1:0] in_char_code;
  logic [tts_pkg::ROW_W-1:0]  in_read_row;
  logic [tts_pkg::COL_W-1:0]  in_read_column;
  logic                       out_valid;
  logic                       out_stall;
  logic [tts_pkg::CELL_W-1:0] out_cell_value;
  logic [tts_pkg::ROW_W-1:0]  out_cursor_row;
  logic [tts_pkg::COL_W-1:0]  out_cursor_column;
  logic                       out_scrolled;

  int error_count;
  int pending_results;
  int idle_cycles;
  int hold_req;   // bump to ask the receiver for one long hold-off
  int burst_left; // transactions left in the current sender burst

  always #2 clk = ~clk;

  text_terminal_cursor_scroll dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_value    (out_cell_value),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column),
    .out_scrolled      (out_scrolled)
  );

  tts_reply_check reply_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_value    (out_cell_value),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column),
    .out_scrolled      (out_scrolled),
    .error_count       (error_count),
    .pending_results   (pending_results)
  );

  // Watchdog: a scroll, the clearing pass or the long hold-off can block both
  // sides; a stretch past IDLE_LIMIT with no transaction on either side means
  // the block is stuck.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stretches of random length, each with its own stall rate
  // (none, light, half, heavy, nearly always). A bumped hold_req makes it
  // hold stall high through the long hold-off.
  initial begin : receiver_stall
    int seen;
    int pct;
    int stretch;
    seen = 0;
    out_stall <= 1'b0;
    forever begin
      case ($urandom_range(0, 4))
        0:       pct = 0;
        1:       pct = 25;
        2:       pct = 50;
        3:       pct = 75;
        default: pct = 95;
      endcase
      stretch = $urandom_range(10, 150);
      repeat (stretch) begin
        @(posedge clk);
        if (hold_req != seen) begin
          seen = hold_req;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // End the current burst with a gap once its count runs out. Gaps are
  // mostly short, sometimes long; a zero-length burst never happens.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one transaction and hold it until the block takes it.
  task automatic send_item(input tts_tb_pkg::term_mode_e mode,
                           input logic [tts_pkg::CHAR_W-1:0] ch,
                           input logic [tts_pkg::ROW_W-1:0] rrow,
                           input logic [tts_pkg::COL_W-1:0] rcol);
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_char_code   <= ch;
    in_read_row    <= rrow;
    in_read_column <= rcol;
    do @(posedge clk); while (in_stall);
    pace_sender();
  endtask

  task automatic send_put(input logic [tts_pkg::CHAR_W-1:0] ch);
    // Read coordinates are don't-care on a put; fill them with noise.
    send_item(tts_tb_pkg::MODE_PUT, ch, tts_pkg::ROW_W'($urandom),
              tts_pkg::COL_W'($urandom));
  endtask

  task automatic send_read(input logic [tts_pkg::ROW_W-1:0] rrow,
                           input logic [tts_pkg::COL_W-1:0] rcol);
    send_item(tts_tb_pkg::MODE_READ, tts_pkg::CHAR_W'($urandom), rrow, rcol);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Change the text color only with nothing in flight.
  task automatic write_text_color(input logic [tts_pkg::CHAR_W-1:0] color);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mix: mostly ordinary characters (which wrap lines and eventually
  // scroll), some newlines, and reads that are mostly in range with a few
  // anywhere in the full field width.
  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 7)
      send_put(tts_pkg::CHAR_NEWLINE);
    else if (pick < 60)
      send_put(tts_pkg::CHAR_W'($urandom_range(0, 255)));
    else if (pick < 94)
      send_read(tts_pkg::ROW_W'($urandom_range(0, tts_pkg::ROWS - 1)),
                tts_pkg::COL_W'($urandom_range(0, tts_pkg::COLUMNS - 1)));
    else
      send_read(tts_pkg::ROW_W'($urandom_range(0, 31)),
                tts_pkg::COL_W'($urandom_range(0, 127)));
  endtask

  initial begin : stimulus
    logic [tts_pkg::CHAR_W-1:0] phase_color;
    hold_req       <= 0;
    idle_cycles    <= 0;
    burst_left      = 10;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_mode        <= tts_tb_pkg::MODE_PUT;
    in_char_code   <= '0;
    in_read_row    <= '0;
    in_read_column <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, edge and out-of-range reads, extreme
    // characters, a newline, then more cells under other colors.
    write_text_color(tts_pkg::COLOR_RESET);
    send_read(5'd0, 7'd0);
    send_read(tts_pkg::ROW_W'(tts_pkg::ROWS - 1), tts_pkg::COL_W'(tts_pkg::COLUMNS - 1));
    send_read(tts_pkg::ROW_W'(tts_pkg::ROWS), 7'd0);     // row just past the screen
    send_read(5'd0, tts_pkg::COL_W'(tts_pkg::COLUMNS));  // column just past the line
    send_read(5'd31, 7'd127);        // both fields at full scale
    send_put(8'h00);
    send_put(8'hFF);
    send_put(8'h41);
    send_put(tts_pkg::CHAR_NEWLINE); // no cell written, cursor to next row
    send_put(tts_pkg::CHAR_SPACE);
    send_read(5'd0, 7'd0);
    send_read(5'd0, 7'd1);
    send_read(5'd1, 7'd0);
    write_text_color(8'hFF);
    send_put(8'h55);
    send_put(8'hAA);
    send_read(5'd1, 7'd1);
    write_text_color(8'h00);
    send_put(8'h7F);
    send_put(tts_pkg::CHAR_NEWLINE);
    send_read(5'd1, 7'd2);

    // Random phases, one text color each, extremes first.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_color = 8'hFF;
        1:       phase_color = 8'h00;
        3:       phase_color = 8'h1E;
        default: phase_color = tts_pkg::CHAR_W'($urandom_range(0, 255));
      endcase
      write_text_color(phase_color);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold off the receiver while the sender keeps offering back to back,
        // so the block fills and stalls its input.
        if (p == 1 && n == 100) begin
          hold_req  <= hold_req + 1;
          burst_left = 60;
        end
        // Pause the sender until every result is out.
        if (p == 3 && n == 180)
          wait_drained();
        send_random_item();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
